>>> rtl/core/ilid_pkg.sv
// ----------------------------------------------------------------------------
// ilid_pkg
// shared types and constants of the indexed list engine
// ----------------------------------------------------------------------------
`default_nettype none

package ilid_pkg;

	localparam int DATA_W       = 32;
	localparam int POS_W        = 8;
	localparam int FUNC_W       = 3;
	localparam int STATUS_W     = 2;
	localparam int COUNT_W      = 7;
	localparam int CAPACITY_DEF = 64;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_READ     = 3'd0,
		FUNC_INS_HEAD = 3'd1,
		FUNC_APPEND   = 3'd2,
		FUNC_INS_POS  = 3'd3,
		FUNC_DELETE   = 3'd4
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic ins;
		logic del;
		logic rd;
	} cell_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/indexed_list_insert_delete.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete
// ordered list of signed 32-bit values with read, insert and delete by position
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells; an insert or delete shifts every
// cell at or past the target position at once, so those operations (and every
// refused operation) return their result in the cycle after acceptance, and the
// next transaction can be taken in that same cycle. A read registers the
// addressed cell value and feeds it to a registered four-input or-tree of
// ceil(log4(CAPACITY)) levels; its result is registered into the output once
// it has left the last level, and no transaction is taken meanwhile. Input is
// also held off while an unaccepted result waits in the output register. Cell
// contents need no clearing after reset; only occupancy and control are reset.
`default_nettype none

module indexed_list_insert_delete #(
	parameter int CAPACITY = ilid_pkg::CAPACITY_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [ilid_pkg::FUNC_W-1:0]   func,
	input  wire logic [ilid_pkg::POS_W-1:0]    position,
	input  wire logic [ilid_pkg::DATA_W-1:0]   data_in,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [ilid_pkg::DATA_W-1:0]   data_out,
	output logic      [ilid_pkg::STATUS_W-1:0] status,
	output logic      [ilid_pkg::COUNT_W-1:0]  count
);
	import ilid_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int OW = $clog2(CAPACITY + 1);
	localparam int IW = (OW > COUNT_W) ? OW : COUNT_W;
	localparam int L  = ($clog2(CAPACITY) + 1) / 2;
	localparam int RW = $clog2(L + 1);

	logic [OW-1:0]       occ_q;
	logic                busy_q;
	logic [RW-1:0]       rd_cnt_q;
	logic                out_valid_q;
	logic [DATA_W-1:0]   data_out_q;
	status_t             status_q;
	logic [COUNT_W-1:0]  count_q;

	logic                acc;
	logic                pos_neg;
	logic [IW-1:0]       pos_e;
	logic [IW-1:0]       occ_e;
	logic                full;
	logic                ok_rw;
	logic                ins_rng_ok;
	logic                do_ins;
	logic                do_del;
	logic                do_rd;
	status_t             st;
	logic [AW-1:0]       at;
	logic [OW-1:0]       occ_nxt;
	logic [IW-1:0]       cnt_e;
	cell_cmd_t           cmd;

	logic [DATA_W-1:0]          q    [CAPACITY];
	logic [CAPACITY*DATA_W-1:0] rd_bus;
	logic [DATA_W-1:0]          tree_out;

	assign in_stall = busy_q | (out_valid_q & out_stall);
	assign acc      = in_valid & ~in_stall;

	assign pos_neg    = position[POS_W-1];
	assign pos_e      = IW'(position[POS_W-2:0]);
	assign occ_e      = IW'(occ_q);
	assign full       = occ_q >= OW'(CAPACITY);
	assign ok_rw      = ~pos_neg & (pos_e < occ_e);
	assign ins_rng_ok = pos_neg | (pos_e <= occ_e);

	always_comb begin
		do_ins = 1'b0;
		do_del = 1'b0;
		do_rd  = 1'b0;
		st     = ST_DONE;
		at     = pos_e[AW-1:0];
		unique case (func_t'(func))
			FUNC_READ: begin
				if (ok_rw) do_rd = 1'b1;
				else st = ST_RANGE;
			end
			FUNC_INS_HEAD: begin
				at = '0;
				if (full) st = ST_FULL;
				else do_ins = 1'b1;
			end
			FUNC_APPEND: begin
				at = occ_e[AW-1:0];
				if (full) st = ST_FULL;
				else do_ins = 1'b1;
			end
			FUNC_INS_POS: begin
				if (pos_neg) at = '0;
				if (!ins_rng_ok) st = ST_RANGE;
				else if (full) st = ST_FULL;
				else do_ins = 1'b1;
			end
			FUNC_DELETE: begin
				if (ok_rw) do_del = 1'b1;
				else st = ST_RANGE;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		occ_nxt = occ_q;
		if (do_ins) occ_nxt = occ_q + OW'(1);
		else if (do_del) occ_nxt = occ_q - OW'(1);
	end

	assign cnt_e = IW'(occ_nxt);

	assign cmd.ins = acc & do_ins;
	assign cmd.del = acc & do_del;
	assign cmd.rd  = acc & do_rd;

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			logic [DATA_W-1:0] prev_v;
			logic [DATA_W-1:0] next_v;
			if (i == 0) begin : g_head
				assign prev_v = data_in;
			end else begin : g_body
				assign prev_v = q[i-1];
			end
			if (i == CAPACITY - 1) begin : g_tail
				assign next_v = q[i];
			end else begin : g_mid
				assign next_v = q[i+1];
			end
			ilid_cell #(
				.INDEX(i),
				.AW(AW)
			) u_cell (
				.clk(clk),
				.cmd(cmd),
				.at(at),
				.value(data_in),
				.prev(prev_v),
				.next(next_v),
				.q(q[i]),
				.rd_s1(rd_bus[i*DATA_W +: DATA_W])
			);
		end
	endgenerate

	ilid_or_tree #(
		.N(CAPACITY),
		.W(DATA_W)
	) u_tree (
		.clk(clk),
		.din(rd_bus),
		.dout(tree_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			busy_q      <= 1'b0;
			rd_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				occ_q <= occ_nxt;
				if (do_rd) begin
					busy_q      <= 1'b1;
					rd_cnt_q    <= '0;
					out_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (rd_cnt_q == RW'(L)) begin
					busy_q      <= 1'b0;
					out_valid_q <= 1'b1;
				end else begin
					rd_cnt_q <= rd_cnt_q + RW'(1);
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			data_out_q <= '0;
			status_q   <= st;
			count_q    <= cnt_e[COUNT_W-1:0];
		end else if (busy_q && (rd_cnt_q == RW'(L))) begin
			data_out_q <= tree_out;
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;
	assign status    = status_q;
	assign count     = count_q;

endmodule

`default_nettype wire

>>> rtl/core/ilid_cell.sv
// ----------------------------------------------------------------------------
// ilid_cell
// one list slot: shifts up on insert, down on delete, gates its value on read
// ----------------------------------------------------------------------------
`default_nettype none

module ilid_cell #(
	parameter int INDEX = 0,
	parameter int AW    = 6
) (
	input  wire logic                       clk,
	input  wire ilid_pkg::cell_cmd_t        cmd,
	input  wire logic [AW-1:0]              at,
	input  wire logic [ilid_pkg::DATA_W-1:0] value,
	input  wire logic [ilid_pkg::DATA_W-1:0] prev,
	input  wire logic [ilid_pkg::DATA_W-1:0] next,
	output logic      [ilid_pkg::DATA_W-1:0] q,
	output logic      [ilid_pkg::DATA_W-1:0] rd_s1
);
	import ilid_pkg::*;

	localparam logic [AW-1:0] IDX = AW'(INDEX);

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (IDX > at) begin
				q <= prev;
			end else if (IDX == at) begin
				q <= value;
			end
		end else if (cmd.del && (IDX >= at)) begin
			q <= next;
		end
		rd_s1 <= (cmd.rd && (IDX == at)) ? q : '0;
	end

endmodule

`default_nettype wire

>>> rtl/core/ilid_or_tree.sv
// ----------------------------------------------------------------------------
// ilid_or_tree
// registered four-input or-reduction tree over the gated cell values
// ----------------------------------------------------------------------------
`default_nettype none

module ilid_or_tree #(
	parameter int N = 64,
	parameter int W = 32
) (
	input  wire logic         clk,
	input  wire logic [N*W-1:0] din,
	output logic      [W-1:0] dout
);

	localparam int L = ($clog2(N) + 1) / 2;
	localparam int P = 1 << (2 * L);

	logic [W-1:0] leaf [P];
	logic [W-1:0] lv   [L][P];

	genvar i, k, j;
	generate
		for (i = 0; i < P; i++) begin : g_leaf
			if (i < N) begin : g_in
				assign leaf[i] = din[i*W +: W];
			end else begin : g_pad
				assign leaf[i] = '0;
			end
		end
		for (k = 0; k < L; k++) begin : g_lvl
			for (j = 0; j < (P >> (2 * (k + 1))); j++) begin : g_node
				if (k == 0) begin : g_first
					always_ff @(posedge clk) begin
						lv[k][j] <= leaf[4*j] | leaf[4*j+1] | leaf[4*j+2] | leaf[4*j+3];
					end
				end else begin : g_upper
					always_ff @(posedge clk) begin
						lv[k][j] <= lv[k-1][4*j] | lv[k-1][4*j+1]
							| lv[k-1][4*j+2] | lv[k-1][4*j+3];
					end
				end
			end
		end
	endgenerate

	assign dout = lv[L-1][0];

endmodule

`default_nettype wire
